@@ rtl/fp32dp_pkg.sv @@
// Shared constants, types and state encodings of the fp32 dot product block.
package fp32dp_pkg;

  localparam int LANES_DEF = 16;
  localparam int ELEMS_DEF = 4;

  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
  localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
  localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LANE,
    ST_ALIGN,
    ST_MRG_GO,
    ST_MRG_WAIT,
    ST_HOLD
  } top_state_t;

  typedef enum logic [3:0] {
    F_IDLE,
    F_MUL,
    F_LZ,
    F_SHIFT,
    F_CMP,
    F_ALN,
    F_ADD,
    F_NRM,
    F_SH2,
    F_RND,
    F_PACK
  } fma_step_t;

  typedef struct packed {
    logic start;
    logic clear;
  } merge_ctl_t;

endpackage

@@ rtl/fp32dp_fma.sv @@
// Multi-cycle single-precision fused multiply-add with one round-to-nearest-even rounding.
module fp32dp_fma
  import fp32dp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  output logic        done,
  output logic [31:0] res
);

  function automatic logic [5:0] msb_pos(input logic [62:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 63; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

  fma_step_t state_r, state_nxt;

  logic [31:0] a_r, b_r, c_r;
  logic        sp_r, sc_r, spec_r, cz_r, zero_r, rsign_r, sub_r, top_r;
  logic [31:0] spec_val_r;
  logic [47:0] mp_r;
  logic [23:0] mc_r;
  logic signed [11:0] ep_r, ec_r, d_r, e_r;
  logic [5:0]  shp_r, shc_r, shl_r;
  logic [61:0] mpn_r, mcn_r, big_r, small_r, m_r;
  logic [62:0] sum_r;
  logic [23:0] keep_r;
  logic        inc_r, ovf_r, tiny_r, bepos_r;
  logic [7:0]  be8_r;
  logic [31:0] res_r;
  logic        done_r;

  logic [7:0]  ea, eb, ec, eax, ebx, ecx;
  logic [22:0] fa, fb, fc;
  logic        sa, sb, sc, sp, az, bz, cz, an, bn, cn;
  logic [23:0] ma, mb, mc;
  logic        pbig;
  logic [61:0] sh_small;
  logic [62:0] sum_v;
  logic signed [11:0] be, sh;
  logic [5:0]  sh6, shg;
  logic [61:0] m_g;
  logic [24:0] k;
  logic [31:0] bits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == F_PACK);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (start) state_nxt = F_MUL;
      F_MUL:   state_nxt = F_LZ;
      F_LZ:    state_nxt = F_SHIFT;
      F_SHIFT: state_nxt = F_CMP;
      F_CMP:   state_nxt = F_ALN;
      F_ALN:   state_nxt = F_ADD;
      F_ADD:   state_nxt = F_NRM;
      F_NRM:   state_nxt = F_SH2;
      F_SH2:   state_nxt = F_RND;
      F_RND:   state_nxt = F_PACK;
      F_PACK:  state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    sa = a_r[31];
    sb = b_r[31];
    sc = c_r[31];
    sp = sa ^ sb;
    ea = a_r[30:23];
    eb = b_r[30:23];
    ec = c_r[30:23];
    fa = a_r[22:0];
    fb = b_r[22:0];
    fc = c_r[22:0];
    az = (ea == 8'd0) && (fa == 23'd0);
    bz = (eb == 8'd0) && (fb == 23'd0);
    cz = (ec == 8'd0) && (fc == 23'd0);
    an = (ea == 8'hFF) && (fa != 23'd0);
    bn = (eb == 8'hFF) && (fb != 23'd0);
    cn = (ec == 8'hFF) && (fc != 23'd0);
    eax = (ea == 8'd0) ? 8'd1 : ea;
    ebx = (eb == 8'd0) ? 8'd1 : eb;
    ecx = (ec == 8'd0) ? 8'd1 : ec;
    ma = {(ea != 8'd0), fa};
    mb = {(eb != 8'd0), fb};
    mc = {(ec != 8'd0), fc};

    pbig = (ep_r > ec_r) || ((ep_r == ec_r) && (mpn_r >= mcn_r));

    sh_small = small_r >> d_r[5:0];

    if (sub_r) sum_v = {1'b0, big_r} - {1'b0, small_r};
    else       sum_v = {1'b0, big_r} + {1'b0, small_r};

    be  = e_r + 12'sd188;
    sh  = (be >= 12'sd1) ? 12'sd38 : (12'sd39 - be);
    sh6 = sh[5:0];
    shg = sh6 - 6'd1;
    m_g = m_r >> shg;

    k    = {1'b0, keep_r} + {24'd0, inc_r};
    bits = bepos_r ? ({1'b0, be8_r, 23'd0} + {7'd0, k}) : {7'd0, k};
    if (bits >= INF_BITS) bits = INF_BITS;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        if (start) begin
          a_r <= a;
          b_r <= b;
          c_r <= c;
        end
      end
      F_MUL: begin
        sp_r <= sp;
        sc_r <= sc;
        cz_r <= cz;
        mp_r <= 48'(ma) * 48'(mb);
        mc_r <= mc;
        ep_r <= $signed({4'd0, eax}) + $signed({4'd0, ebx}) - 12'sd300;
        ec_r <= $signed({4'd0, ecx}) - 12'sd150;
        spec_r <= 1'b1;
        if (an || bn || cn) begin
          spec_val_r <= QNAN_BITS;
        end else if ((ea == 8'hFF) || (eb == 8'hFF)) begin
          if (az || bz) spec_val_r <= QNAN_BITS;
          else if ((ec == 8'hFF) && (sc != sp)) spec_val_r <= QNAN_BITS;
          else spec_val_r <= {sp, INF_BITS[30:0]};
        end else if (ec == 8'hFF) begin
          spec_val_r <= c_r;
        end else if (az || bz) begin
          if (cz) spec_val_r <= (sp == sc) ? {sp, 31'd0} : 32'd0;
          else spec_val_r <= c_r;
        end else begin
          spec_r     <= 1'b0;
          spec_val_r <= 32'd0;
        end
      end
      F_LZ: begin
        shp_r <= 6'd61 - msb_pos({15'd0, mp_r});
        shc_r <= 6'd61 - msb_pos({39'd0, mc_r});
      end
      F_SHIFT: begin
        mpn_r <= 62'(mp_r) << shp_r;
        mcn_r <= 62'(mc_r) << shc_r;
        ep_r  <= ep_r - $signed({6'd0, shp_r});
        ec_r  <= ec_r - $signed({6'd0, shc_r});
      end
      F_CMP: begin
        if (cz_r) begin
          big_r   <= mpn_r;
          small_r <= '0;
          d_r     <= '0;
          e_r     <= ep_r;
          rsign_r <= sp_r;
          sub_r   <= 1'b0;
        end else begin
          sub_r <= (sp_r != sc_r);
          if (pbig) begin
            big_r   <= mpn_r;
            small_r <= mcn_r;
            d_r     <= ep_r - ec_r;
            e_r     <= ep_r;
            rsign_r <= sp_r;
          end else begin
            big_r   <= mcn_r;
            small_r <= mpn_r;
            d_r     <= ec_r - ep_r;
            e_r     <= ec_r;
            rsign_r <= sc_r;
          end
        end
      end
      F_ALN: begin
        if (d_r >= 12'sd63) begin
          small_r <= 62'd1;
        end else if (d_r > 12'sd0) begin
          small_r <= sh_small | {61'd0, ((sh_small << d_r[5:0]) != small_r)};
        end
      end
      F_ADD: begin
        sum_r  <= sum_v;
        zero_r <= sub_r && (sum_v == 63'd0);
      end
      F_NRM: begin
        top_r <= sum_r[62];
        shl_r <= 6'd61 - msb_pos(sum_r);
      end
      F_SH2: begin
        if (top_r) begin
          m_r <= sum_r[62:1] | {61'd0, sum_r[0]};
          e_r <= e_r + 12'sd1;
        end else begin
          m_r <= sum_r[61:0] << shl_r;
          e_r <= e_r - $signed({6'd0, shl_r});
        end
      end
      F_RND: begin
        ovf_r   <= (be >= 12'sd255);
        tiny_r  <= (sh >= 12'sd63);
        bepos_r <= (be >= 12'sd1);
        be8_r   <= be[7:0] - 8'd1;
        keep_r  <= 24'(m_r >> sh6);
        inc_r   <= m_g[0] && (((m_g << shg) != m_r) || m_g[1]);
      end
      F_PACK: begin
        if (spec_r)      res_r <= spec_val_r;
        else if (zero_r) res_r <= 32'd0;
        else if (ovf_r)  res_r <= {rsign_r, INF_BITS[30:0]};
        else if (tiny_r) res_r <= {rsign_r, 31'd0};
        else             res_r <= {rsign_r, bits[30:0]};
      end
      default: begin
      end
    endcase
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

@@ rtl/fp32dp_merge.sv @@
// Reduction stage that adds the lane sums in order into one running total.
module fp32dp_merge
  import fp32dp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  merge_ctl_t  ctl,
  input  logic [31:0] lane_val,
  output logic        done,
  output logic [31:0] sum
);

  logic [31:0] sum_r;
  logic        fma_done;
  logic [31:0] fma_res;

  fp32dp_fma u_fma (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.start),
    .a     (lane_val),
    .b     (ONE_BITS),
    .c     (sum_r),
    .done  (fma_done),
    .res   (fma_res)
  );

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      sum_r <= 32'd0;
    end else if (fma_done) begin
      sum_r <= fma_res;
    end
  end

  assign done = fma_done;
  assign sum  = sum_r;

endmodule

@@ rtl/fp32_dot_product.sv @@
// Top level of the streaming fp32 dot product with parallel lane accumulators.
// Each transaction carries up to four element pairs that ELEMS_PER_ITEM fused multiply-add
// lanes process side by side; the next transaction can be taken only once the 10-step
// multiply-add unit and the accumulator update of the last one have finished.
// After a transaction with in_last set, the LANES accumulators are first rotated into lane
// order and then summed one lane after the other by the merge unit, before the result is
// offered on the output.
module fp32_dot_product
  import fp32dp_pkg::*;
#(
  parameter int LANES          = LANES_DEF,
  parameter int ELEMS_PER_ITEM = ELEMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_x_a,
  input  logic [31:0] in_x_b,
  input  logic [31:0] in_x_c,
  input  logic [31:0] in_x_d,
  input  logic [31:0] in_y_a,
  input  logic [31:0] in_y_b,
  input  logic [31:0] in_y_c,
  input  logic [31:0] in_y_d,
  input  logic [2:0]  in_valid_count,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_dot_bits
);

  localparam int BW = $clog2(LANES);

  top_state_t  state_r, state_nxt;
  logic [31:0] acc_r [LANES];
  logic [31:0] acc_nxt [LANES];
  logic [31:0] upd [LANES];
  logic [BW-1:0] base_r, base_nxt, mcnt_r, mcnt_nxt;
  logic [BW:0]   base_sum;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        last_r, last_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_dot_r, out_dot_nxt;
  logic        lane_start;
  logic [31:0] lane_res [ELEMS_PER_ITEM];
  logic [ELEMS_PER_ITEM-1:0] lane_done;
  logic [31:0] x_in [4];
  logic [31:0] y_in [4];
  merge_ctl_t  mctl;
  logic        mrg_done;
  logic [31:0] mrg_sum;

  assign x_in[0] = in_x_a;
  assign x_in[1] = in_x_b;
  assign x_in[2] = in_x_c;
  assign x_in[3] = in_x_d;
  assign y_in[0] = in_y_a;
  assign y_in[1] = in_y_b;
  assign y_in[2] = in_y_c;
  assign y_in[3] = in_y_d;

  for (genvar e = 0; e < ELEMS_PER_ITEM; e++) begin : g_lane
    fp32dp_fma u_fma (
      .clk   (clk),
      .rst_n (rst_n),
      .start (lane_start),
      .a     (x_in[e]),
      .b     (y_in[e]),
      .c     (acc_r[e]),
      .done  (lane_done[e]),
      .res   (lane_res[e])
    );
  end

  fp32dp_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mctl),
    .lane_val (acc_r[0]),
    .done     (mrg_done),
    .sum      (mrg_sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= '0;
      mcnt_r      <= '0;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LANES; i++) acc_r[i] <= 32'd0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      mcnt_r      <= mcnt_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < LANES; i++) acc_r[i] <= acc_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    out_dot_r <= out_dot_nxt;
  end

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      upd[j] = acc_r[j];
    end
    for (int j = 0; j < ELEMS_PER_ITEM; j++) begin
      if (3'(j) < cnt_r) upd[j] = lane_res[j];
    end
    base_sum = {1'b0, base_r} + (BW+1)'(ELEMS_PER_ITEM);
    if (base_sum >= (BW+1)'(LANES)) base_sum = base_sum - (BW+1)'(LANES);
  end

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    mcnt_nxt      = mcnt_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_dot_nxt   = out_dot_r;
    lane_start    = 1'b0;
    mctl          = '0;
    for (int i = 0; i < LANES; i++) acc_nxt[i] = acc_r[i];
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          lane_start = 1'b1;
          last_nxt   = in_last;
          if (in_last && (in_valid_count < 3'(ELEMS_PER_ITEM))) cnt_nxt = in_valid_count;
          else cnt_nxt = 3'(ELEMS_PER_ITEM);
          state_nxt = ST_LANE;
        end
      end
      ST_LANE: begin
        if (lane_done[0]) begin
          for (int i = 0; i < LANES; i++) acc_nxt[i] = upd[(i + ELEMS_PER_ITEM) % LANES];
          base_nxt  = base_sum[BW-1:0];
          state_nxt = last_r ? ST_ALIGN : ST_IDLE;
        end
      end
      ST_ALIGN: begin
        if (base_r == '0) begin
          mctl.clear = 1'b1;
          mcnt_nxt   = '0;
          state_nxt  = ST_MRG_GO;
        end else begin
          for (int i = 0; i < LANES; i++) acc_nxt[i] = acc_r[(i + 1) % LANES];
          if (base_r == BW'(LANES - 1)) base_nxt = '0;
          else base_nxt = base_r + 1'b1;
        end
      end
      ST_MRG_GO: begin
        mctl.start = 1'b1;
        state_nxt  = ST_MRG_WAIT;
      end
      ST_MRG_WAIT: begin
        if (mrg_done) begin
          for (int i = 0; i < LANES; i++) acc_nxt[i] = acc_r[(i + 1) % LANES];
          if (mcnt_r == BW'(LANES - 1)) begin
            state_nxt = ST_HOLD;
          end else begin
            mcnt_nxt  = mcnt_r + 1'b1;
            state_nxt = ST_MRG_GO;
          end
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_dot_nxt   = mrg_sum;
          for (int i = 0; i < LANES; i++) acc_nxt[i] = 32'd0;
          base_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall     = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_dot_bits = out_dot_r;

endmodule

@@ rtl/fp32dp_check.sv @@
// Port-level checker for the fp32 dot product and its bind to the top level.
module fp32dp_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_dot_bits
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_dot_bits))
    else $error("stalled result transaction changed");

  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last |=> in_stall)
    else $error("input taken during reduction");

  a_rise_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a reduction");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result right after an input transaction");

endmodule

bind fp32_dot_product fp32dp_check u_check (.*);
